// ----- rtl/sm4_pkg.sv -----
// Package with SM4 constants, S-box and round functions.
package sm4_pkg;

	localparam int RoundCount = 32;
	localparam int RkAw = $clog2(RoundCount);

	localparam logic [2:0] REG_KEY_HIGH = 3'd0;
	localparam logic [2:0] REG_KEY_LOW = 3'd1;
	localparam logic [2:0] REG_IV_HIGH = 3'd2;
	localparam logic [2:0] REG_IV_LOW = 3'd3;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [2:0] REG_DIRECTION = 3'd5;

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	typedef logic [7:0] sbox_arr_t [256];

	localparam sbox_arr_t SBOX = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] a);
		return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] lin_round(input logic [31:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	function automatic logic [31:0] ck_word(input logic [RkAw-1:0] i);
		logic [7:0] base;
		base = {1'b0, i, 2'b00} * 8'd7;
		return {base, base + 8'd7, base + 8'd14, base + 8'd21};
	endfunction

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] iv_high;
		logic [63:0] iv_low;
		logic chain_mode;
		logic direction;
		logic key_written;
	} cfg_t;

endpackage

// ----- rtl/sm4_regs.sv -----
// APB configuration register file for the SM4 block.
module sm4_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output sm4_pkg::cfg_t cfg
);
	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic chain_mode_q, direction_q, wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
			chain_mode_q <= 1'b0;
			direction_q <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				sm4_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				sm4_pkg::REG_KEY_LOW: key_low_q <= pwdata;
				sm4_pkg::REG_IV_HIGH: iv_high_q <= pwdata;
				sm4_pkg::REG_IV_LOW: iv_low_q <= pwdata;
				sm4_pkg::REG_CHAIN_MODE: chain_mode_q <= pwdata[0];
				sm4_pkg::REG_DIRECTION: direction_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sm4_pkg::REG_KEY_HIGH: prdata = key_high_q;
			sm4_pkg::REG_KEY_LOW: prdata = key_low_q;
			sm4_pkg::REG_IV_HIGH: prdata = iv_high_q;
			sm4_pkg::REG_IV_LOW: prdata = iv_low_q;
			sm4_pkg::REG_CHAIN_MODE: prdata = {63'd0, chain_mode_q};
			sm4_pkg::REG_DIRECTION: prdata = {63'd0, direction_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.key_high = key_high_q;
	assign cfg.key_low = key_low_q;
	assign cfg.iv_high = iv_high_q;
	assign cfg.iv_low = iv_low_q;
	assign cfg.chain_mode = chain_mode_q;
	assign cfg.direction = direction_q;
	assign cfg.key_written = wr && (idx == sm4_pkg::REG_KEY_HIGH || idx == sm4_pkg::REG_KEY_LOW);
endmodule

// ----- rtl/sm4_block_cipher_ecb_cbc_top.sv -----
// Top level of the SM4 ECB/CBC block cipher with padding.
// Each 128-bit word is processed one round per cycle through one shared round unit,
// with keys read from a 32-entry round key memory through a registered read port
// that a prime state (ST_PRIME) starts; after any key write the first word also waits
// for a key expansion (ST_KEY) that fills the memory. The result sits in an output
// register, and the next word is accepted once the round unit is idle and that result
// has been taken.
module sm4_block_cipher_ecb_cbc_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic first_block,
	input  logic final_block,
	input  logic [4:0] valid_bytes,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic out_final,
	output logic [4:0] strip_count,
	output logic padding_bad
);
	localparam int Aw = sm4_pkg::RkAw;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEY = 4'b0010,
		ST_PRIME = 4'b0100,
		ST_ROUND = 4'b1000
	} state_t;

	sm4_pkg::cfg_t cfg;
	state_t state_q;
	logic stale_q, dec_q, fin_q, cbc_q, out_busy_q, outv_q;
	logic [Aw:0] cnt_q;
	logic [31:0] x0_q, x1_q, x2_q, x3_q;
	logic [31:0] rk_mem [sm4_pkg::RoundCount];
	logic [31:0] rk_rd_q;
	logic [63:0] cv_hi_q, cv_lo_q, in_hi_q, in_lo_q;
	logic [127:0] obuf_q;
	logic ofin_q, obad_q;
	logic [4:0] ostrip_q;
	logic [Aw-1:0] rd_addr;
	logic [31:0] tk, nk, tr, nr;
	logic acc, round_last;
	logic [127:0] blk, padded, res, fin_res;
	logic [4:0] pad;
	logic bad;

	sm4_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	assign in_ready = (state_q == ST_IDLE) && !out_busy_q;
	assign acc = in_valid && in_ready;
	assign round_last = (state_q == ST_ROUND) &&
		(cnt_q == (Aw+1)'(sm4_pkg::RoundCount - 1));

	assign tk = x1_q ^ x2_q ^ x3_q ^ sm4_pkg::ck_word(cnt_q[Aw-1:0]);
	assign nk = x0_q ^ sm4_pkg::lin_key(sm4_pkg::tau(tk));
	assign tr = x1_q ^ x2_q ^ x3_q ^ rk_rd_q;
	assign nr = x0_q ^ sm4_pkg::lin_round(sm4_pkg::tau(tr));

	always_comb begin
		logic [Aw:0] n;
		n = (state_q == ST_ROUND) ? cnt_q + 1'b1 : '0;
		rd_addr = dec_q ? ~n[Aw-1:0] : n[Aw-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			rk_mem[cnt_q[Aw-1:0]] <= nk;
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	always_comb begin
		padded = {block_high, block_low};
		if (!cfg.direction && final_block && valid_bytes >= 5'd1 && valid_bytes <= 5'd15) begin
			for (int k = 0; k < 16; k++) begin
				if (k >= int'(valid_bytes)) begin
					padded[127-8*k -: 8] = 8'(5'd16 - valid_bytes);
				end
			end
		end
		blk = padded;
		if (cfg.chain_mode && !cfg.direction) begin
			blk = first_block ? padded ^ {cfg.iv_high, cfg.iv_low} : padded ^ {cv_hi_q, cv_lo_q};
		end
	end

	assign res = {nr, x3_q, x2_q, x1_q};

	always_comb begin
		fin_res = res;
		if (cbc_q && dec_q) begin
			fin_res = res ^ {cv_hi_q, cv_lo_q};
		end
		pad = 5'd0;
		bad = 1'b0;
		if (dec_q && fin_q) begin
			if (fin_res[7:0] > 8'd16) begin
				bad = 1'b1;
			end else begin
				for (int k = 0; k < 16; k++) begin
					if (k >= 16 - int'(fin_res[7:0]) && fin_res[127-8*k -: 8] != fin_res[7:0]) begin
						bad = 1'b1;
					end
				end
				if (!bad) begin
					pad = fin_res[4:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stale_q <= 1'b1;
			cnt_q <= '0;
			outv_q <= 1'b0;
			out_busy_q <= 1'b0;
			cv_hi_q <= '0;
			cv_lo_q <= '0;
		end else begin
			if (cfg.key_written) begin
				stale_q <= 1'b1;
			end
			if (outv_q && out_ready) begin
				outv_q <= 1'b0;
				out_busy_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						out_busy_q <= 1'b1;
						cnt_q <= '0;
						if (cfg.chain_mode && first_block) begin
							cv_hi_q <= cfg.iv_high;
							cv_lo_q <= cfg.iv_low;
						end
						state_q <= stale_q ? ST_KEY : ST_PRIME;
					end
				end
				ST_KEY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (Aw+1)'(sm4_pkg::RoundCount - 1)) begin
						stale_q <= 1'b0;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					cnt_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (round_last) begin
						outv_q <= 1'b1;
						state_q <= ST_IDLE;
						if (cbc_q) begin
							if (dec_q) begin
								cv_hi_q <= in_hi_q;
								cv_lo_q <= in_lo_q;
							end else begin
								cv_hi_q <= res[127:64];
								cv_lo_q <= res[63:0];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_q <= cfg.direction;
			cbc_q <= cfg.chain_mode;
			fin_q <= final_block;
			in_hi_q <= padded[127:64];
			in_lo_q <= padded[63:0];
			if (stale_q) begin
				x0_q <= cfg.key_high[63:32] ^ sm4_pkg::FK0;
				x1_q <= cfg.key_high[31:0] ^ sm4_pkg::FK1;
				x2_q <= cfg.key_low[63:32] ^ sm4_pkg::FK2;
				x3_q <= cfg.key_low[31:0] ^ sm4_pkg::FK3;
			end else begin
				{x0_q, x1_q, x2_q, x3_q} <= blk;
			end
		end else if (state_q == ST_KEY) begin
			if (cnt_q == (Aw+1)'(sm4_pkg::RoundCount - 1)) begin
				if (cbc_q && !dec_q) begin
					{x0_q, x1_q, x2_q, x3_q} <= {in_hi_q, in_lo_q} ^ {cv_hi_q, cv_lo_q};
				end else begin
					{x0_q, x1_q, x2_q, x3_q} <= {in_hi_q, in_lo_q};
				end
			end else begin
				{x0_q, x1_q, x2_q, x3_q} <= {x1_q, x2_q, x3_q, nk};
			end
		end else if (state_q == ST_ROUND) begin
			{x0_q, x1_q, x2_q, x3_q} <= {x1_q, x2_q, x3_q, nr};
		end
		if (round_last) begin
			obuf_q <= fin_res;
			ofin_q <= fin_q;
			ostrip_q <= pad;
			obad_q <= bad;
		end
	end

	assign out_valid = outv_q;
	assign out_high = obuf_q[127:64];
	assign out_low = obuf_q[63:0];
	assign out_final = ofin_q;
	assign strip_count = ostrip_q;
	assign padding_bad = obad_q;

	a_busy_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input accepted while busy");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		round_last |=> out_valid) else $error("result not presented");
	a_key_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> !stale_q || $past(cfg.key_written, 1)) else $error("stale keys");
	a_strip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && padding_bad |-> strip_count == 5'd0) else $error("strip with bad pad");
endmodule
